/* rtl/qwt_pkg.sv */
// Shared types, codes and constants of the quoted word tokenizer.
// No dependencies; the lexer, queue, top level, checker and testbench import this package.
`default_nettype none

package qwt_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [6:0] ARG_LIMIT_RST = 7'd32;
  localparam logic [6:0] MAX_LIMIT     = 7'd64;
  localparam logic [7:0] DQUOTE        = 8'h22;
  localparam logic [7:0] SQUOTE        = 8'h27;

  typedef enum logic [2:0] {
    MODE_GAP  = 3'd0,
    MODE_WORD = 3'd1,
    MODE_DQ   = 3'd2,
    MODE_SQ   = 3'd3,
    MODE_STOP = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic [5:0] word_index;
    logic [5:0] word_count;
    logic       last;
  } res_t;

  // Up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

`default_nettype wire

/* rtl/qwt_if.sv */
// Valid/ready channel interfaces for the tokenizer input and result streams.
// Depends on nothing; payload widths follow the block's field list.
`default_nettype none

interface qwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_mark;

  modport source (output valid, char_in, end_mark, input ready);
  modport sink   (input valid, char_in, end_mark, output ready);
endinterface

interface qwt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [5:0] word_index;
  logic [5:0] word_count;
  logic       last;

  modport source (output valid, kind, char_out, word_index, word_count, last, input ready);
  modport sink   (input valid, kind, char_out, word_index, word_count, last, output ready);
endinterface

`default_nettype wire

/* rtl/qwt_lexer.sv */
// Lexer state (mode, word count, limit register) and per-character result logic.
// Depends on qwt_pkg; feeds zero to two results per accepted word to qwt_outq.
`default_nettype none

module qwt_lexer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [6:0]    cfg_wdata_i,
  input  wire logic          fire_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          end_i,
  output qwt_pkg::push_t     push_o
);
  import qwt_pkg::*;

  mode_e      mode_q, mode_d, m;
  logic [5:0] seen_q, seen_d, s, idx;
  logic [6:0] arg_q, lim;
  logic       go, sp;
  res_t       r0, r1;
  logic [1:0] n;

  always_comb begin
    m      = mode_q;
    s      = seen_q;
    mode_d = mode_q;
    go     = 1'b1;
    n      = 2'd0;
    idx    = 6'd0;
    r0     = '0;
    r1     = '0;
    sp     = is_space(char_i);
    lim    = (arg_q > MAX_LIMIT) ? MAX_LIMIT : arg_q;

    if (end_i) begin
      mode_d        = MODE_GAP;
      r0.word_count = seen_q;
      r1.word_count = seen_q;
      if (mode_q inside {MODE_WORD, MODE_DQ, MODE_SQ}) begin
        r0.kind       = KIND_END;
        r0.word_index = (seen_q == 6'd0) ? 6'd0 : seen_q - 6'd1;
        r1.kind       = (mode_q == MODE_WORD) ? KIND_DONE : KIND_ERR;
        r1.last       = 1'b1;
        n             = 2'd2;
      end else begin
        r0.kind = KIND_DONE;
        r0.last = 1'b1;
        n       = 2'd1;
      end
      s = 6'd0;
    end else begin
      if (m == MODE_GAP) begin
        if (sp) begin
          go = 1'b0;
        end else if ({1'b0, s} + 7'd1 >= lim) begin
          mode_d = MODE_STOP;
          go     = 1'b0;
        end else begin
          s = s + 6'd1;
          m = MODE_WORD;
        end
      end
      idx           = (s == 6'd0) ? 6'd0 : s - 6'd1;
      r0.word_index = idx;
      r0.word_count = s;
      r0.char_out   = char_i;
      r0.last       = 1'b1;
      if (go) begin
        mode_d = m;
        case (m)
          MODE_WORD: begin
            if (char_i == DQUOTE) begin
              mode_d = MODE_DQ;
            end else if (char_i == SQUOTE) begin
              mode_d = MODE_SQ;
            end else if (sp) begin
              r0.kind     = KIND_END;
              r0.char_out = 8'd0;
              n           = 2'd1;
              mode_d      = MODE_GAP;
            end else begin
              n = 2'd1;
            end
          end
          MODE_DQ: begin
            if (char_i == DQUOTE) mode_d = MODE_WORD;
            else                  n = 2'd1;
          end
          MODE_SQ: begin
            if (char_i == SQUOTE) mode_d = MODE_WORD;
            else                  n = 2'd1;
          end
          default: begin
            mode_d = MODE_STOP;
          end
        endcase
      end
    end
    seen_d    = s;
    push_o.n  = fire_i ? n : 2'd0;
    push_o.r0 = r0;
    push_o.r1 = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GAP;
      seen_q <= 6'd0;
      arg_q  <= ARG_LIMIT_RST;
    end else begin
      if (fire_i) begin
        mode_q <= mode_d;
        seen_q <= seen_d;
      end
      if (cfg_we_i) begin
        arg_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qwt_outq.sv */
// Small result queue that takes up to two words per cycle and emits one while ready_i is high.
// Depends on qwt_pkg; sits between qwt_lexer and the result channel.
`default_nettype none

module qwt_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire qwt_pkg::push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output qwt_pkg::res_t      head_o
);
  import qwt_pkg::*;

  res_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  // Leave room for the worst case of two results from the next word
  assign room_o  = (cnt_q <= CNT_W'(QDEPTH - 2));
  assign head_o  = mem_q[rd_q];
  assign cnt_d   = cnt_q + CNT_W'(push_i.n) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.n);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/quoted_word_tokenizer_unit.sv */
// Top level of the quoted word tokenizer: lexer plus result queue.
// Depends on qwt_pkg, qwt_if, qwt_lexer and qwt_outq.
//
// Takes one character (or end-of-line word) per cycle while input ready is high,
// and splits the line into words, honoring double and single quotes. Each input
// word yields zero, one or two result words, written into the result queue when
// the input is accepted. A four-entry result queue decouples the two sides: input
// ready is high while the queue holds at most two results, so a stream of one
// result per character sustains one character per cycle while the result channel
// is ready, and only an end of line inside a word or a quoted span yields two
// results. Write arg_limit only while the block is idle.
`default_nettype none

module quoted_word_tokenizer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  qwt_in_if.sink          in_i,
  qwt_out_if.source       out_o
);
  import qwt_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  fire;

  assign in_i.ready = room;
  assign fire       = in_i.valid && room;

  qwt_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .char_i     (in_i.char_in),
    .end_i      (in_i.end_mark),
    .push_o     (push)
  );

  qwt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .head_o (head)
  );

  assign out_o.kind       = head.kind;
  assign out_o.char_out   = head.char_out;
  assign out_o.word_index = head.word_index;
  assign out_o.word_count = head.word_count;
  assign out_o.last       = head.last;

endmodule

`default_nettype wire

/* rtl/qwt_checker.sv */
// Port-level checks of the tokenizer result stream, bound to the top level.
// Depends on qwt_pkg and quoted_word_tokenizer_unit.
`default_nettype none

module qwt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_char,
  input wire logic [5:0] out_index,
  input wire logic       out_last
);
  import qwt_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Line done and error always close the word's results
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ERR)
      |-> out_last && out_index == 6'd0)
    else $error("end-of-line result malformed");

  // Only character results carry a byte
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_CHAR |-> out_char == 8'd0)
    else $error("non-character result carries a byte");

  // Nothing comes out of a queue that reset has emptied
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quoted_word_tokenizer_unit qwt_checker u_qwt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_kind (out_o.kind),
  .out_char (out_o.char_out),
  .out_index(out_o.word_index),
  .out_last (out_o.last)
);

`default_nettype wire

/* test/tb_quoted_word_tokenizer_unit.sv */
// Self-checking testbench for quoted_word_tokenizer_unit: directed lines, then random
// command lines under several arg_limit settings and idle patterns.
// Depends on qwt_pkg, qwt_if and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_quoted_word_tokenizer_unit;
  import qwt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;

  qwt_in_if  in_ch ();
  qwt_out_if out_ch ();

  quoted_word_tokenizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  line_item_t pending_chars[$];
  res_t       expected_tokens[$];
  line_item_t on_bus;
  logic       bus_busy;
  res_t       head_token;
  int         mismatches;
  int         queued_count;
  int         send_idle_pct;
  int         recv_stall_pct;

  // Tokenizer state as predicted
  mode_e      scan_mode;
  logic [5:0] word_total;
  logic [6:0] slot_limit;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [5:0] open_index();
    return (word_total == 6'd0) ? 6'd0 : word_total - 6'd1;
  endfunction

  function automatic res_t token(input kind_e k, input logic [7:0] ch, input logic [5:0] idx);
    res_t r;
    r.kind       = k;
    r.char_out   = ch;
    r.word_index = idx;
    r.word_count = word_total;
    r.last       = 1'b0;
    return r;
  endfunction

  // Advance the predicted tokenizer by one accepted word and queue its results
  task automatic split_char(input logic [7:0] ch, input logic eol);
    res_t       made[2];
    int         n;
    logic [6:0] cap;
    n   = 0;
    cap = (slot_limit > MAX_LIMIT) ? MAX_LIMIT : slot_limit;
    if (eol) begin
      if (scan_mode == MODE_WORD || scan_mode == MODE_DQ || scan_mode == MODE_SQ) begin
        made[n] = token(KIND_END, 8'd0, open_index());
        n++;
      end
      if (scan_mode == MODE_DQ || scan_mode == MODE_SQ) begin
        made[n] = token(KIND_ERR, 8'd0, 6'd0);
      end else begin
        made[n] = token(KIND_DONE, 8'd0, 6'd0);
      end
      n++;
      scan_mode  = MODE_GAP;
      word_total = 6'd0;
    end else begin
      if (scan_mode == MODE_GAP && !blank(ch)) begin
        if ({1'b0, word_total} + 7'd1 >= cap) begin
          scan_mode = MODE_STOP;
        end else begin
          word_total = word_total + 6'd1;
          scan_mode  = MODE_WORD;
        end
      end
      case (scan_mode)
        MODE_WORD: begin
          if (ch == DQUOTE) begin
            scan_mode = MODE_DQ;
          end else if (ch == SQUOTE) begin
            scan_mode = MODE_SQ;
          end else if (blank(ch)) begin
            made[n] = token(KIND_END, 8'd0, open_index());
            n++;
            scan_mode = MODE_GAP;
          end else begin
            made[n] = token(KIND_CHAR, ch, open_index());
            n++;
          end
        end
        MODE_DQ: begin
          if (ch == DQUOTE) begin
            scan_mode = MODE_WORD;
          end else begin
            made[n] = token(KIND_CHAR, ch, open_index());
            n++;
          end
        end
        MODE_SQ: begin
          if (ch == SQUOTE) begin
            scan_mode = MODE_WORD;
          end else begin
            made[n] = token(KIND_CHAR, ch, open_index());
            n++;
          end
        end
        default: ;
      endcase
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(made[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: hold a word until accepted, then maybe idle before the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        split_char(on_bus.ch, on_bus.eol);
        bus_busy = 1'b0;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus   = pending_chars.pop_front();
          bus_busy = 1'b1;
          in_ch.valid    <= 1'b1;
          in_ch.char_in  <= on_bus.ch;
          in_ch.end_mark <= on_bus.eol;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result word: kind %0d char %0h", out_ch.kind, out_ch.char_out);
          mismatches++;
        end else begin
          head_token = expected_tokens.pop_front();
          check_field("kind", 8'(head_token.kind), 8'(out_ch.kind));
          check_field("char_out", head_token.char_out, out_ch.char_out);
          check_field("word_index", 8'(head_token.word_index), 8'(out_ch.word_index));
          check_field("word_count", 8'(head_token.word_count), 8'(out_ch.word_count));
          check_field("last", 8'(head_token.last), 8'(out_ch.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] ch, input logic eol);
    line_item_t it;
    it.ch  = ch;
    it.eol = eol;
    pending_chars.push_back(it);
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(1) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (blank(c) || c == DQUOTE || c == SQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] pick_quoted(input logic [7:0] q);
    logic [7:0] c;
    if ($urandom_range(3) == 0) return pick_blank();
    do c = 8'($urandom_range(0, 255));
    while (c == q);
    return c;
  endfunction

  task automatic queue_segment();
    logic [7:0] q;
    case ($urandom_range(2))
      0: repeat ($urandom_range(1, 4)) queue_byte(pick_plain(), 1'b0);
      default: begin
        q = ($urandom_range(1) == 0) ? DQUOTE : SQUOTE;
        queue_byte(q, 1'b0);
        repeat ($urandom_range(0, 4)) queue_byte(pick_quoted(q), 1'b0);
        queue_byte(q, 1'b0);
      end
    endcase
  endtask

  // One command line: mostly well formed, some with noise or an open quote,
  // some long enough to run into the word limit
  task automatic queue_line();
    int style;
    int words;
    int w;
    style = $urandom_range(0, 9);
    words = (style == 0) ? $urandom_range(58, 70) : $urandom_range(0, 7);
    for (w = 0; w < words; w++) begin
      repeat ($urandom_range((w == 0) ? 0 : 1, 2)) queue_byte(pick_blank(), 1'b0);
      if (style == 0) queue_byte(pick_plain(), 1'b0);
      else repeat ($urandom_range(1, 3)) queue_segment();
    end
    case (style)
      1: repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      2: begin
        queue_byte(($urandom_range(1) == 0) ? DQUOTE : SQUOTE, 1'b0);
        repeat ($urandom_range(0, 3)) queue_byte(pick_plain(), 1'b0);
      end
      default: ;
    endcase
    if ($urandom_range(3) == 0) queue_byte(pick_blank(), 1'b0);
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Wait until every word is in and every result is out, plus some slack
  task automatic drain();
    while (pending_chars.size() != 0 || bus_busy || expected_tokens.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_arg_limit(input logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    slot_limit   = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int lim[6];
    int budget[6];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.char_in  = '0;
    in_ch.end_mark = 1'b0;
    out_ch.ready   = 1'b0;
    bus_busy       = 1'b0;
    mismatches     = 0;
    queued_count   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    scan_mode      = MODE_GAP;
    word_total     = '0;
    slot_limit     = ARG_LIMIT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines at the reset limit
    queue_text("a \"b c\"'' \"\"");
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0B, 1'b0);
    queue_byte(SQUOTE, 1'b0);
    queue_byte(DQUOTE, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("\"x");
    queue_byte(8'h00, 1'b1);
    queue_text("z");
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);
    drain();

    // Directed limit cases: one slot, zero slots, stop at a word that opens a quote
    set_arg_limit(7'd1);
    queue_text("a");
    queue_byte(8'h00, 1'b1);
    drain();
    set_arg_limit(7'd0);
    queue_text("b c");
    queue_byte(8'h00, 1'b1);
    drain();
    set_arg_limit(7'd2);
    queue_text("a \"b");
    queue_byte(8'h00, 1'b1);
    drain();

    lim    = '{64, 1, 127, 5, 0, 32};
    budget = '{260, 40, 260, 180, 40, 220};
    lim[5] = $urandom_range(1, 64);
    for (int p = 0; p < 6; p++) begin
      set_arg_limit(7'(lim[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      queued_count = 0;
      while (queued_count < budget[p]) queue_line();
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* quoted_word_tokenizer_unit.f */
rtl/qwt_pkg.sv
rtl/qwt_if.sv
rtl/qwt_lexer.sv
rtl/qwt_outq.sv
rtl/quoted_word_tokenizer_unit.sv
rtl/qwt_checker.sv
test/tb_quoted_word_tokenizer_unit.sv
